>>> rtl/acst_pkg.sv
// ----------------------------------------------------------------------------
// acst_pkg
// Shared types and constants for the sample-to-Celsius text pipeline.
// ----------------------------------------------------------------------------
package acst_pkg;

  localparam int unsigned SampleW = 10;
  localparam int unsigned HundW   = 16;
  localparam int unsigned IntW    = 9;
  localparam int unsigned LineLen = 8;
  localparam int unsigned CntW    = 4;

  localparam logic [31:0] RECIP_100 = 32'd83887;

  localparam logic [7:0] ASCII_ZERO = 8'h30;
  localparam logic [7:0] ASCII_DOT  = 8'h2E;
  localparam logic [7:0] ASCII_CR   = 8'h0D;
  localparam logic [7:0] ASCII_LF   = 8'h0A;
  localparam logic [7:0] ASCII_NUL  = 8'h00;

  typedef struct packed {
    logic [IntW-1:0]  int_part;
    logic [HundW-1:0] hund;
  } quot_t;

  typedef struct packed {
    logic       has_hund;
    logic       has_tens;
    logic [3:0] hund_d;
    logic [3:0] tens_d;
    logic [3:0] ones_d;
    logic [3:0] frac_t;
    logic [3:0] frac_o;
  } digits_t;

endpackage

>>> rtl/acst_scale.sv
// ----------------------------------------------------------------------------
// acst_scale
// Three-stage scaler: sample to hundredths of a degree, then integer part.
// ----------------------------------------------------------------------------
module acst_scale
  import acst_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [SampleW-1:0] sample,
  output logic               out_valid,
  input  logic               out_ready,
  output quot_t              out_q
);

  logic        v1, v2, v3;
  logic        rdy1, rdy2, rdy3;
  logic [15:0] s1_base;
  logic [19:0] s1_y;
  logic [15:0] s2_hund;
  quot_t       s3_q;

  logic [15:0] base_c;
  logic [19:0] y_c;
  logic [9:0]  q1_c;
  logic [10:0] r1_c;
  logic        qc_c;
  logic [15:0] hund_c;
  logic [31:0] prod_c;

  assign rdy3     = !v3 || out_ready;
  assign rdy2     = !v2 || rdy3;
  assign rdy1     = !v1 || rdy2;
  assign in_ready = rdy1;

  // 50000 = 48*1023 + 896
  assign base_c = (16'(sample) << 5) + (16'(sample) << 4);
  assign y_c    = (20'(sample) << 9) + (20'(sample) << 8) + (20'(sample) << 7);

  // floor(y/1023): y>>10 plus one correction
  assign q1_c   = s1_y[19:10];
  assign r1_c   = 11'(s1_y[9:0]) + 11'(q1_c);
  assign qc_c   = (r1_c >= 11'd1023);
  assign hund_c = s1_base + 16'(q1_c) + 16'(qc_c);

  assign prod_c = 32'(s2_hund) * RECIP_100;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (rdy1) v1 <= in_valid;
      if (rdy2) v2 <= v1;
      if (rdy3) v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1 && in_valid) begin
      s1_base <= base_c;
      s1_y    <= y_c;
    end
    if (rdy2 && v1) begin
      s2_hund <= hund_c;
    end
    if (rdy3 && v2) begin
      s3_q.int_part <= prod_c[31:23];
      s3_q.hund     <= s2_hund;
    end
  end

  assign out_valid = v3;
  assign out_q     = s3_q;

endmodule

>>> rtl/acst_digits.sv
// ----------------------------------------------------------------------------
// acst_digits
// Splits the integer and fraction parts into decimal digits.
// ----------------------------------------------------------------------------
module acst_digits
  import acst_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_ready,
  input  quot_t   in_q,
  output logic    out_valid,
  input  logic    out_ready,
  output digits_t out_d
);

  logic        v;
  digits_t     d_reg;
  digits_t     d_c;
  logic [6:0]  fr_c;
  logic [13:0] frp_c;
  logic [3:0]  ft_c;
  logic [14:0] hp_c;
  logic [2:0]  hd_c;
  logic [16:0] tp_c;
  logic [5:0]  q10_c;

  assign in_ready = !v || out_ready;

  always_comb begin
    fr_c  = 7'(in_q.hund - 16'(in_q.int_part) * 16'd100);
    frp_c = 14'(fr_c) * 14'd103;
    ft_c  = frp_c[13:10];
    hp_c  = 15'(in_q.int_part) * 15'd41;
    hd_c  = hp_c[14:12];
    tp_c  = 17'(in_q.int_part) * 17'd205;
    q10_c = tp_c[16:11];
    d_c.has_hund = (in_q.int_part >= 9'd100);
    d_c.has_tens = (in_q.int_part >= 9'd10);
    d_c.hund_d   = 4'(hd_c);
    d_c.tens_d   = 4'(q10_c - 6'(hd_c) * 6'd10);
    d_c.ones_d   = 4'(in_q.int_part - 9'(q10_c) * 9'd10);
    d_c.frac_t   = ft_c;
    d_c.frac_o   = 4'(fr_c - 7'(ft_c) * 7'd10);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= 1'b0;
    end else if (in_ready) begin
      v <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      d_reg <= d_c;
    end
  end

  assign out_valid = v;
  assign out_d     = d_reg;

endmodule

>>> rtl/acst_ser.sv
// ----------------------------------------------------------------------------
// acst_ser
// Builds the text line and shifts it out one character per request.
// ----------------------------------------------------------------------------
module acst_ser
  import acst_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  digits_t   in_d,
  output logic      m_tvalid,
  input  logic      m_tready,
  output logic [7:0] m_tdata,
  output logic      m_tlast
);

  logic [7:0]      line [LineLen];
  logic [7:0]      line_next [LineLen];
  logic [CntW-1:0] cnt;
  logic [CntW-1:0] len_c;
  logic [7:0]      ch_h, ch_t, ch_o, ch_ft, ch_fo;
  logic            load;
  logic            take;

  assign take     = m_tvalid && m_tready;
  assign in_ready = (cnt == '0) || ((cnt == CntW'(1)) && m_tready);
  assign load     = in_valid && in_ready;

  assign ch_h  = ASCII_ZERO + 8'(in_d.hund_d);
  assign ch_t  = ASCII_ZERO + 8'(in_d.tens_d);
  assign ch_o  = ASCII_ZERO + 8'(in_d.ones_d);
  assign ch_ft = ASCII_ZERO + 8'(in_d.frac_t);
  assign ch_fo = ASCII_ZERO + 8'(in_d.frac_o);
  assign len_c = CntW'(6) + CntW'(in_d.has_hund) + CntW'(in_d.has_tens);

  always_comb begin
    if (in_d.has_hund) begin
      line_next = '{ch_h, ch_t, ch_o, ASCII_DOT, ch_ft, ch_fo, ASCII_CR, ASCII_LF};
    end else if (in_d.has_tens) begin
      line_next = '{ch_t, ch_o, ASCII_DOT, ch_ft, ch_fo, ASCII_CR, ASCII_LF, ASCII_NUL};
    end else begin
      line_next = '{ch_o, ASCII_DOT, ch_ft, ch_fo, ASCII_CR, ASCII_LF, ASCII_NUL, ASCII_NUL};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (load) begin
      cnt <= len_c;
    end else if (take) begin
      cnt <= cnt - CntW'(1);
    end
  end

  // advance the line by one character per request
  always_ff @(posedge clk) begin
    if (load) begin
      line <= line_next;
    end else if (take) begin
      for (int i = 0; i < LineLen - 1; i++) begin
        line[i] <= line[i+1];
      end
      line[LineLen-1] <= ASCII_NUL;
    end
  end

  assign m_tvalid = (cnt != '0);
  assign m_tdata  = line[0];
  assign m_tlast  = (cnt == CntW'(1));

  a_last_is_lf: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tlast |-> m_tdata == ASCII_LF)
    else $error("last character is not a line feed");

  a_cnt_range: assert property (@(posedge clk) disable iff (rst)
    cnt <= CntW'(LineLen))
    else $error("character count out of range");

  a_load_len: assert property (@(posedge clk) disable iff (rst)
    load |=> (cnt >= CntW'(6)) && (cnt <= CntW'(8)))
    else $error("loaded line length out of range");

  a_load_when_done: assert property (@(posedge clk) disable iff (rst)
    load |-> (cnt == '0) || (take && m_tlast))
    else $error("line loaded over pending characters");

endmodule

>>> rtl/adc_sample_to_celsius_text_core.sv
// ----------------------------------------------------------------------------
// adc_sample_to_celsius_text_core
// Converts a 10-bit converter sample to a Celsius text line, one char out.
// ----------------------------------------------------------------------------
// Path: a sample passes the three scale stages and the digit register,
//   then is loaded into the output line. One sample per line of 6 to 8
//   characters, one character per cycle while m_tready is high; the four
//   arithmetic stages hold up to four more samples while a line is sent.
// Reset: synchronous rst empties all stages and the output line.
module adc_sample_to_celsius_text_core
  import acst_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // [9:0] sample, [15:10] zero
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // [7:0] text_char
  output logic        m_tlast
);

  logic    q_valid, q_ready;
  quot_t   q;
  logic    d_valid, d_ready;
  digits_t d;

  acst_scale u_scale (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .sample    (s_tdata[SampleW-1:0]),
    .out_valid (q_valid),
    .out_ready (q_ready),
    .out_q     (q)
  );

  acst_digits u_digits (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (q_valid),
    .in_ready  (q_ready),
    .in_q      (q),
    .out_valid (d_valid),
    .out_ready (d_ready),
    .out_d     (d)
  );

  acst_ser u_ser (
    .clk      (clk),
    .rst      (rst),
    .in_valid (d_valid),
    .in_ready (d_ready),
    .in_d     (d),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

endmodule
